// ===== hw/rtl/dsd_pkg.sv =====
// Shared types for the duplicate-removing descending sorter.
// Holds the controller state, read-address selection and the command/status
// structs. Depends on nothing.
`timescale 1ns / 1ps

package dsd_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_INSERT,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_IDX_NEXT,
        RD_COUNT_M1,
        RD_K_M2,
        RD_EMIT
    } t_rd_sel;

    typedef struct packed {
        logic    ld_item;
        logic    scan_step;
        logic    pos_from_idx;
        logic    pos_from_count;
        logic    set_dropped;
        logic    shift_start;
        logic    shift_step;
        logic    insert;
        logic    emit_start;
        logic    emit_load;
        logic    clear_list;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic rd_gt;
        logic rd_eq;
        logic scan_end;
        logic shift_done;
        logic last_item;
        logic out_busy;
        logic emit_last;
    } t_status;

endpackage

// ===== hw/rtl/dsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dsd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dsd_datapath.sv =====
// Datapath of the sorter: the sorted store, item, pointers, counters and
// the output register. Depends on dsd_pkg and dsd_ram.
`timescale 1ns / 1ps

module dsd_datapath import dsd_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_value_res,
    output logic                     o_last_res,
    output logic                     o_overflow
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic signed [WORD_W-1:0] r_value;
    logic                     r_last;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_pos;
    logic [AW-1:0]            r_k;
    logic [AW-1:0]            r_e;
    logic [CW-1:0]            r_count;
    logic                     r_dropped;

    logic signed [WORD_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;
    logic                     r_out_valid;

    logic                     we;
    logic [AW-1:0]            waddr;
    logic [WORD_W-1:0]        wdata;
    logic [AW-1:0]            raddr;
    logic [WORD_W-1:0]        rdata_raw;
    logic signed [WORD_W-1:0] rdata;

    dsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata = $signed(rdata_raw);

    // Store writes: a shift moves the entry just read one place down; an
    // insert places the held value at its position.
    assign we    = i_cmd.shift_step | i_cmd.insert;
    assign waddr = i_cmd.insert ? r_pos : r_k;
    assign wdata = i_cmd.insert ? r_value : rdata;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO:     raddr = '0;
            RD_IDX_NEXT: raddr = r_idx + AW'(1);
            RD_COUNT_M1: raddr = AW'(r_count - CW'(1));
            RD_K_M2:     raddr = r_k - AW'(2);
            RD_EMIT:     raddr = r_e;
            default:     raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_value <= i_value;
            r_last  <= i_last;
            r_idx   <= '0;
            r_pos   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.pos_from_idx) begin
            r_pos <= r_idx;
        end
        if (i_cmd.pos_from_count) begin
            r_pos <= r_count[AW-1:0];
        end
        if (i_cmd.shift_start) begin
            r_k <= r_count[AW-1:0];
        end
        if (i_cmd.shift_step) begin
            r_k <= r_k - AW'(1);
        end
        if (i_cmd.emit_start) begin
            r_e <= '0;
        end
        if (i_cmd.emit_load) begin
            r_e         <= r_e + AW'(1);
            r_out_value <= rdata;
            r_out_last  <= o_status.emit_last;
            r_out_ovf   <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_list) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else begin
                if (i_cmd.insert) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.set_dropped) begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.count_zero = (r_count == '0);
        o_status.full       = (r_count >= CW'(CAPACITY));
        o_status.rd_gt      = (rdata > r_value);
        o_status.rd_eq      = (rdata == r_value);
        o_status.scan_end   = ((CW'(r_idx) + CW'(1)) == r_count);
        o_status.shift_done = ((CW'(r_pos) + CW'(1)) == CW'(r_k));
        o_status.last_item  = r_last;
        o_status.out_busy   = r_out_valid & ~i_ready;
        o_status.emit_last  = ((CW'(r_e) + CW'(1)) == r_count);
    end

    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_last_res  = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

// ===== hw/rtl/dsd_ctrl.sv =====
// Controller of the sorter: sequences scan, shift, insert and emission.
// Depends on dsd_pkg.
`timescale 1ns / 1ps

module dsd_ctrl import dsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.rd_sel = RD_ZERO;
                if (i_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = i_status.count_zero ? ST_INSERT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_sel = RD_IDX_NEXT;
                if (i_status.rd_eq) begin
                    // Value already held: nothing to store.
                    if (i_status.last_item) begin
                        o_cmd.emit_start = 1'b1;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_status.rd_gt && !i_status.scan_end) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_status.full) begin
                    o_cmd.set_dropped = 1'b1;
                    if (i_status.last_item) begin
                        o_cmd.emit_start = 1'b1;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_status.rd_gt) begin
                    o_cmd.pos_from_count = 1'b1;
                    n_state = ST_INSERT;
                end else begin
                    o_cmd.pos_from_idx = 1'b1;
                    o_cmd.shift_start  = 1'b1;
                    o_cmd.rd_sel       = RD_COUNT_M1;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.rd_sel     = RD_K_M2;
                o_cmd.shift_step = 1'b1;
                if (i_status.shift_done) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                if (i_status.last_item) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_sel = RD_EMIT;
                if (!i_status.out_busy) begin
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                o_cmd.emit_load = 1'b1;
                if (i_status.emit_last) begin
                    o_cmd.clear_list = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dedup_sort_descending.sv =====
// Top level of the duplicate-removing descending sorter.
// Joins the controller (dsd_ctrl) and the datapath (dsd_datapath); uses dsd_pkg.
// Depends on dsd_pkg, dsd_ctrl, dsd_datapath and dsd_ram.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-------------------------------------------
//   input    | i_valid / o_ready  | i_value (signed 32), i_last
//   output   | o_valid / i_ready  | o_value_res (signed 32), o_last_res,
//            |                    | o_overflow
//
// Steps: an item is first transferred, then the stored entries are examined
// in turn while searching for its place (at most the fill count), the entries
// below it are moved down one at a time to open a gap, and it is written. The
// store has a single read and a single write port. After the final item each
// result is read from the store and then loaded into the output register.
// Reset is synchronous and active low; it empties the list at once, so no
// clearing pass is needed. A stalled output holds the emission; the final
// result may wait in the output register while the next list is already
// being taken in.
`timescale 1ns / 1ps

module dedup_sort_descending import dsd_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_value_res,
    output logic                     o_last_res,
    output logic                     o_overflow
);

    // Commands from the controller to the datapath, status back.
    t_cmd    cmd;
    t_status status;

    // The controller owns the sequencing: search the descending store for
    // the first entry not larger than the new value, drop it on a match or
    // when the store is full, otherwise shift the smaller entries down and
    // write it in. On the final item it walks the store from the top.
    dsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds the store memory, the item under work, the search
    // and shift pointers, the fill count, the overflow flag and the output
    // register that decouples the result channel.
    dsd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

endmodule
